// ===== rtl/oaht_pkg.sv =====
package oaht_pkg;

    // request action codes
    localparam logic [1:0] ACT_SET = 2'd0;
    localparam logic [1:0] ACT_GET = 2'd1;
    localparam logic [1:0] ACT_DEL = 2'd2;

    // result status codes
    localparam logic [1:0] RES_OK   = 2'd0;
    localparam logic [1:0] RES_MISS = 2'd1;
    localparam logic [1:0] RES_FULL = 2'd2;

    typedef enum logic [1:0] {
        OP_SET,
        OP_GET,
        OP_DEL,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        SLOT_EMPTY,
        SLOT_LIVE,
        SLOT_TOMB
    } t_slot_st;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MOD,
        F_HOLD
    } t_fstate;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_DONE
    } t_bstate;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key_id;
        logic [31:0] key_hash;
        logic [63:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        key_added;
        logic [63:0] read_value;
    } t_out_item;

    typedef struct packed {
        t_op         op;
        logic [31:0] key_id;
        logic [63:0] write_value;
    } t_req;

endpackage

// ===== rtl/oaht_front.sv =====
module oaht_front #(
    parameter int TABLE_SLOTS = 64,
    localparam int IW = $clog2(TABLE_SLOTS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  oaht_pkg::t_in_item  i_in_data,
    input  logic                i_hold,
    output logic                o_q_push,
    input  logic                i_q_full,
    output oaht_pkg::t_req      o_q_req,
    output logic [IW-1:0]       o_q_idx
);

    // one hash byte folded into the running remainder
    function automatic logic [IW-1:0] mod_step(input logic [IW-1:0] rem, input logic [7:0] dig);
        logic [IW+7:0] x;
        x = {rem, dig};
        for (int k = 7; k >= 0; k--) begin
            if (x >= ((IW+8)'(TABLE_SLOTS) << k)) begin
                x = x - ((IW+8)'(TABLE_SLOTS) << k);
            end
        end
        return x[IW-1:0];
    endfunction

    oaht_pkg::t_fstate r_state, n_state;
    logic [1:0]        r_byte, n_byte;
    logic [IW-1:0]     r_rem, n_rem;
    logic [31:0]       r_hash, n_hash;
    oaht_pkg::t_req    r_req, n_req;
    logic [IW-1:0]     step_rem;
    logic              free;
    logic              accept;

    assign step_rem = mod_step(r_rem, r_hash[{~r_byte, 3'b000} +: 8]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oaht_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_byte <= n_byte;
        r_rem  <= n_rem;
        r_hash <= n_hash;
        r_req  <= n_req;
    end

    always_comb begin
        n_state  = r_state;
        n_byte   = r_byte;
        n_rem    = r_rem;
        n_hash   = r_hash;
        n_req    = r_req;
        free     = 1'b0;
        o_q_push = 1'b0;
        o_q_req  = r_req;
        o_q_idx  = step_rem;
        unique case (r_state)
            oaht_pkg::F_IDLE: begin
                free = 1'b1;
            end
            oaht_pkg::F_MOD: begin
                n_rem  = step_rem;
                n_byte = r_byte + 2'd1;
                if (r_byte == 2'd3) begin
                    if (!i_q_full) begin
                        o_q_push = 1'b1;
                        free     = 1'b1;
                        n_state  = oaht_pkg::F_IDLE;
                    end else begin
                        n_state = oaht_pkg::F_HOLD;
                    end
                end
            end
            oaht_pkg::F_HOLD: begin
                o_q_idx = r_rem;
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    free     = 1'b1;
                    n_state  = oaht_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = oaht_pkg::F_IDLE;
            end
        endcase

        o_in_stall = !free || i_hold;
        accept     = i_in_valid && !o_in_stall;

        if (accept) begin
            n_state           = oaht_pkg::F_MOD;
            n_byte            = 2'd0;
            n_rem             = '0;
            n_hash            = i_in_data.key_hash;
            n_req.key_id      = i_in_data.key_id;
            n_req.write_value = i_in_data.write_value;
            unique case (i_in_data.action)
                oaht_pkg::ACT_SET: n_req.op = oaht_pkg::OP_SET;
                oaht_pkg::ACT_GET: n_req.op = oaht_pkg::OP_GET;
                oaht_pkg::ACT_DEL: n_req.op = oaht_pkg::OP_DEL;
                default:           n_req.op = oaht_pkg::OP_NOP;
            endcase
        end
    end

endmodule

// ===== rtl/oaht_queue.sv =====
module oaht_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);

    localparam int DEPTH = 2;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic          r_wp, n_wp;
    logic          r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ===== rtl/oaht_back.sv =====
module oaht_back #(
    parameter int TABLE_SLOTS = 64,
    localparam int IW = $clog2(TABLE_SLOTS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  oaht_pkg::t_req      i_q_req,
    input  logic [IW-1:0]       i_q_idx,
    output logic                o_clearing,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output oaht_pkg::t_out_item o_out_data
);

    localparam int UW       = $clog2(TABLE_SLOTS + 1);
    localparam int LOAD_MAX = (3 * TABLE_SLOTS) / 4;

    // slot memories, one read and one write port each
    oaht_pkg::t_slot_st r_st_mem  [TABLE_SLOTS];
    logic [31:0]        r_key_mem [TABLE_SLOTS];
    logic [63:0]        r_val_mem [TABLE_SLOTS];
    oaht_pkg::t_slot_st r_st_q;
    logic [31:0]        r_key_q;
    logic [63:0]        r_val_q;

    oaht_pkg::t_bstate   r_state, n_state;
    logic [IW-1:0]       r_clr_idx, n_clr_idx;
    logic [UW-1:0]       r_used, n_used;
    oaht_pkg::t_op       r_op, n_op;
    logic [31:0]         r_key, n_key;
    logic [63:0]         r_wval, n_wval;
    logic [IW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_cnt, n_cnt;
    logic                r_tomb_vld, n_tomb_vld;
    logic [IW-1:0]       r_tomb_idx, n_tomb_idx;
    oaht_pkg::t_out_item r_res, n_res;
    logic                r_wr_en, n_wr_en;
    logic                r_wr_kv, n_wr_kv;
    oaht_pkg::t_slot_st  r_wr_st, n_wr_st;
    logic [IW-1:0]       r_wr_idx, n_wr_idx;
    logic                r_inc, n_inc;
    logic                r_out_vld, n_out_vld;
    oaht_pkg::t_out_item r_out, n_out;

    logic [IW-1:0]       rd_addr;
    logic                st_we;
    logic [IW-1:0]       st_wa;
    oaht_pkg::t_slot_st  st_wd;
    logic                kv_we;
    logic [IW-1:0]       nxt_idx;
    logic                f_hit;
    logic                f_empty;
    logic                f_tomb_any;
    logic [IW-1:0]       f_tomb_idx;
    logic                f_last;
    logic                f_done;
    logic                f_avail;
    logic                f_fresh;
    logic [IW-1:0]       f_slot;

    assign o_clearing  = (r_state == oaht_pkg::B_CLEAR);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_st_mem[st_wa] <= st_wd;
        end
        if (kv_we) begin
            r_key_mem[r_wr_idx] <= r_key;
            r_val_mem[r_wr_idx] <= r_wval;
        end
        r_st_q  <= r_st_mem[rd_addr];
        r_key_q <= r_key_mem[rd_addr];
        r_val_q <= r_val_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= oaht_pkg::B_CLEAR;
            r_clr_idx <= '0;
            r_used    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_used    <= n_used;
            r_out_vld <= n_out_vld;
        end
        r_op       <= n_op;
        r_key      <= n_key;
        r_wval     <= n_wval;
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_tomb_vld <= n_tomb_vld;
        r_tomb_idx <= n_tomb_idx;
        r_res      <= n_res;
        r_wr_en    <= n_wr_en;
        r_wr_kv    <= n_wr_kv;
        r_wr_st    <= n_wr_st;
        r_wr_idx   <= n_wr_idx;
        r_inc      <= n_inc;
        r_out      <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        n_used     = r_used;
        n_op       = r_op;
        n_key      = r_key;
        n_wval     = r_wval;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_tomb_vld = r_tomb_vld;
        n_tomb_idx = r_tomb_idx;
        n_res      = r_res;
        n_wr_en    = r_wr_en;
        n_wr_kv    = r_wr_kv;
        n_wr_st    = r_wr_st;
        n_wr_idx   = r_wr_idx;
        n_inc      = r_inc;
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        o_q_pop    = 1'b0;
        rd_addr    = r_idx;
        st_we      = 1'b0;
        st_wa      = r_wr_idx;
        st_wd      = r_wr_st;
        kv_we      = 1'b0;

        nxt_idx    = (r_idx == IW'(TABLE_SLOTS - 1)) ? '0 : r_idx + 1'b1;
        f_hit      = (r_st_q == oaht_pkg::SLOT_LIVE) && (r_key_q == r_key);
        f_empty    = (r_st_q == oaht_pkg::SLOT_EMPTY);
        f_tomb_any = r_tomb_vld || (!f_empty && r_st_q != oaht_pkg::SLOT_LIVE);
        f_tomb_idx = r_tomb_vld ? r_tomb_idx : r_idx;
        f_last     = (r_cnt == IW'(TABLE_SLOTS - 1));
        f_done     = 1'b0;
        f_avail    = 1'b0;
        f_fresh    = 1'b0;
        f_slot     = r_idx;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            oaht_pkg::B_CLEAR: begin
                st_we     = 1'b1;
                st_wa     = r_clr_idx;
                st_wd     = oaht_pkg::SLOT_EMPTY;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IW'(TABLE_SLOTS - 1)) begin
                    n_state = oaht_pkg::B_IDLE;
                end
            end
            oaht_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop          = 1'b1;
                    n_op             = i_q_req.op;
                    n_key            = i_q_req.key_id;
                    n_wval           = i_q_req.write_value;
                    n_idx            = i_q_idx;
                    rd_addr          = i_q_idx;
                    n_cnt            = '0;
                    n_tomb_vld       = 1'b0;
                    n_res.status     = oaht_pkg::RES_MISS;
                    n_res.key_added  = 1'b0;
                    n_res.read_value = '0;
                    n_wr_en          = 1'b0;
                    n_wr_kv          = 1'b0;
                    n_inc            = 1'b0;
                    case (i_q_req.op) inside
                        oaht_pkg::OP_SET: begin
                            if (r_used >= UW'(LOAD_MAX)) begin
                                n_res.status = oaht_pkg::RES_FULL;
                                n_state      = oaht_pkg::B_DONE;
                            end else begin
                                n_state = oaht_pkg::B_PROBE;
                            end
                        end
                        oaht_pkg::OP_GET, oaht_pkg::OP_DEL: begin
                            n_state = (r_used == '0) ? oaht_pkg::B_DONE : oaht_pkg::B_PROBE;
                        end
                        default: begin
                            n_state = oaht_pkg::B_DONE;
                        end
                    endcase
                end
            end
            oaht_pkg::B_PROBE: begin
                if (f_hit) begin
                    f_done  = 1'b1;
                    f_avail = 1'b1;
                    f_slot  = r_idx;
                end else if (f_empty) begin
                    f_done  = 1'b1;
                    f_avail = 1'b1;
                    f_fresh = !r_tomb_vld;
                    f_slot  = r_tomb_vld ? r_tomb_idx : r_idx;
                end else if (f_last) begin
                    f_done  = 1'b1;
                    f_avail = f_tomb_any;
                    f_slot  = f_tomb_idx;
                end else begin
                    n_tomb_vld = f_tomb_any;
                    n_tomb_idx = f_tomb_idx;
                    n_idx      = nxt_idx;
                    rd_addr    = nxt_idx;
                    n_cnt      = r_cnt + 1'b1;
                end

                if (f_done) begin
                    n_state  = oaht_pkg::B_DONE;
                    n_wr_idx = f_slot;
                    case (r_op)
                        oaht_pkg::OP_SET: begin
                            if (f_avail) begin
                                n_res.status    = oaht_pkg::RES_OK;
                                n_res.key_added = !f_hit;
                                n_wr_en         = 1'b1;
                                n_wr_kv         = 1'b1;
                                n_wr_st         = oaht_pkg::SLOT_LIVE;
                                n_inc           = f_fresh;
                            end else begin
                                n_res.status = oaht_pkg::RES_FULL;
                            end
                        end
                        oaht_pkg::OP_GET: begin
                            if (f_hit) begin
                                n_res.status     = oaht_pkg::RES_OK;
                                n_res.read_value = r_val_q;
                            end
                        end
                        oaht_pkg::OP_DEL: begin
                            if (f_hit) begin
                                n_res.status = oaht_pkg::RES_OK;
                                n_wr_en      = 1'b1;
                                n_wr_st      = oaht_pkg::SLOT_TOMB;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            oaht_pkg::B_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    st_we     = r_wr_en;
                    kv_we     = r_wr_kv;
                    n_used    = r_used + UW'(r_inc);
                    n_state   = oaht_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = oaht_pkg::B_IDLE;
            end
        endcase
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(LOAD_MAX))
        else $error("occupancy above load limit");

    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == oaht_pkg::B_CLEAR) |-> !r_out_vld)
        else $error("result produced during clearing pass");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_used != $past(r_used)) |->
            ($past(r_state) == oaht_pkg::B_DONE) && (r_used == $past(r_used) + 1'b1))
        else $error("occupancy changed outside result commit");

endmodule

// ===== rtl/open_addressing_hash_table.sv =====
// channel   direction  handshake               payload
// in        input      i_in_valid / o_in_stall  i_in_data  (action, key_id, key_hash, write_value)
// out       output     o_out_valid / i_out_stall o_out_data (status, key_added, read_value)
//
// front end: one hash byte a cycle reduced mod TABLE_SLOTS, four hash bytes per transaction
// back end: probes the slots one at a time (one read port on the slot memories)
// after reset a clearing pass marks all slots empty, one slot at a time, input stalled
// a two-entry queue parts front and back, an output register parts back and consumer
// result waits in the output register while the back end starts the next transaction
module open_addressing_hash_table #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  oaht_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output oaht_pkg::t_out_item o_out_data
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int QW = $bits(oaht_pkg::t_req) + IW;

    // front to queue
    logic           q_push;
    logic           q_full;
    oaht_pkg::t_req f_req;
    logic [IW-1:0]  f_idx;

    // queue to back
    logic           q_pop;
    logic           q_empty;
    logic [QW-1:0]  q_rdata;
    oaht_pkg::t_req b_req;
    logic [IW-1:0]  b_idx;

    // back end busy with the clearing pass
    logic           clearing;

    assign {b_req, b_idx} = q_rdata;

    // decodes the action and reduces the hash to a start slot
    oaht_front #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_hold     (clearing),
        .o_q_push   (q_push),
        .i_q_full   (q_full),
        .o_q_req    (f_req),
        .o_q_idx    (f_idx)
    );

    // classified requests waiting for the probe engine
    oaht_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata ({f_req, f_idx}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    // linear probe over the slot memories, commits and returns the result
    oaht_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_q_req     (b_req),
        .i_q_idx     (b_idx),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
